[src/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression block.
`default_nettype none
package gbs_pkg;
   localparam int MaxBoxesDefault = 64;
   localparam int CoordWidth = 14;
   localparam int SizeWidth = 13;
   localparam int ScoreWidth = 16;
   localparam int ClassWidth = 8;
   localparam logic [15:0] ThresholdReset = 16'd29491;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic [SizeWidth-1:0] w;
      logic [SizeWidth-1:0] h;
      logic [ScoreWidth-1:0] score;
      logic [ClassWidth-1:0] cls;
   } box_type;

   typedef struct packed {
      box_type box;
      logic last;
   } cand_type;
endpackage
`default_nettype wire

[src/greedy_box_suppression_core.sv]
// Top level of the greedy box suppression block.
`default_nettype none
// Loads a frame of candidate boxes, one per item, until tlast, at one item per
// cycle while the input queue has room and the back end is loading. After the
// last item the block ranks the N stored boxes in place by descending score
// (stable insertion sort) and runs a greedy pass that tests each remaining pair
// in the phases read, grab, geometry, multiply, union and compare after each
// kept box is emitted; no new frame is taken meanwhile. A two-entry
// queue at the input lets the source run ahead by two items. Surviving boxes
// leave in ranking order through an output register; tlast marks the last
// one, tuser flags overflow.
module greedy_box_suppression_core
   import gbs_pkg::*;
#(
   parameter int MAX_BOXES = MaxBoxesDefault
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // box_x[13:0], box_y[27:14], box_width[40:28], box_height[53:41],
   // box_score[69:54], box_class[77:70], zero fill
   input  wire logic [79:0] req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // kept_x, kept_y, kept_width, kept_height, kept_score, kept_class, zero fill
   output logic [79:0]      rsp_tdata,
   output logic             rsp_tlast,
   // dropped_overflow
   output logic             rsp_tuser
);
   logic [15:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= ThresholdReset;
      else if (csr_we) thr_ff <= csr_wdata;
   end

   cand_type in_cand, q_cand;
   logic q_valid, q_ready;
   box_type ob;

   always_comb begin
      in_cand.box.x     = req_tdata[13:0];
      in_cand.box.y     = req_tdata[27:14];
      in_cand.box.w     = req_tdata[40:28];
      in_cand.box.h     = req_tdata[53:41];
      in_cand.box.score = req_tdata[69:54];
      in_cand.box.cls   = req_tdata[77:70];
      in_cand.last      = req_tlast;
   end

   gbs_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cand(in_cand),
      .q_valid(q_valid), .q_ready(q_ready), .q_cand(q_cand)
   );

   gbs_back #(.MaxBoxes(MAX_BOXES)) u_back (
      .clock(clock), .reset(reset), .threshold(thr_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cand(q_cand),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_box(ob), .out_final(rsp_tlast), .out_ovf(rsp_tuser)
   );

   assign rsp_tdata = {2'b00, ob.cls, ob.score, ob.h, ob.w, ob.y, ob.x};
endmodule
`default_nettype wire

[src/gbs_front.sv]
// Front end: registers incoming candidate items into a two-entry queue.
`default_nettype none
module gbs_front
   import gbs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire cand_type in_cand,
   output logic          q_valid,
   input  wire logic     q_ready,
   output cand_type      q_cand
);
   cand_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cand   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_cand;
   end
endmodule
`default_nettype wire

[src/gbs_back.sv]
// Back end: box store, ranking, greedy suppression pass and result register.
`default_nettype none
module gbs_back
   import gbs_pkg::*;
#(
   parameter int MaxBoxes = MaxBoxesDefault
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [15:0]   threshold,
   input  wire logic          q_valid,
   output logic               q_ready,
   input  wire cand_type      q_cand,
   output logic               out_valid,
   input  wire logic          out_ready,
   output box_type            out_box,
   output logic               out_final,
   output logic               out_ovf
);
   localparam int IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
   localparam int CntW = $clog2(MaxBoxes + 1);

   // Phases of one pairwise overlap test.
   localparam logic [2:0] PH_READ  = 3'd0;
   localparam logic [2:0] PH_GRAB  = 3'd1;
   localparam logic [2:0] PH_GEOM  = 3'd2;
   localparam logic [2:0] PH_MUL   = 3'd3;
   localparam logic [2:0] PH_UNION = 3'd4;
   localparam logic [2:0] PH_CMP   = 3'd5;

   typedef enum logic [8:0] {
      S_LOAD = 9'b000000001,
      S_PICK = 9'b000000010,
      S_GRAB = 9'b000000100,
      S_CMP  = 9'b000001000,
      S_SCAN = 9'b000010000,
      S_REF  = 9'b000100000,
      S_EMIT = 9'b001000000,
      S_TEST = 9'b010000000,
      S_WAIT = 9'b100000000
   } state_type;

   state_type state_ff;
   box_type store_mem [MaxBoxes];
   box_type rd_ff;
   logic mem_we;
   logic [IdxW-1:0] mem_wa, mem_ra;
   box_type mem_wd;
   logic [MaxBoxes-1:0] supp_ff;
   logic [CntW-1:0] cnt_ff;
   logic ovf_ff;
   logic [CntW-1:0] i_ff, j_ff;
   box_type ref_ff, cur_ff;
   box_type pend_ff;
   logic pend_v_ff;
   logic [13:0] dx_ff, dy_ff;
   logic [26:0] inter_ff, area_a_ff, area_b_ff;
   logic [27:0] uni_ff;
   logic ov_ff;
   logic [2:0] tph_ff;
   box_type obox_ff;
   logic ofin_ff, oovf_ff, ovalid_ff;
   logic shift_c, load_out_c;

   assign out_valid = ovalid_ff;
   assign out_box   = obox_ff;
   assign out_final = ofin_ff;
   assign out_ovf   = oovf_ff;
   assign q_ready   = (state_ff == S_LOAD);

   wire logic accept = q_valid && q_ready;
   wire logic out_free = !ovalid_ff || out_ready;

   // The store is sorted in place; rd_ff holds the entry addressed in the previous cycle.
   assign shift_c = (j_ff != '0) && (rd_ff.score < cur_ff.score);
   assign load_out_c = ((state_ff == S_EMIT) && pend_v_ff && out_free)
                    || ((state_ff == S_WAIT) && out_free);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = cnt_ff[IdxW-1:0];
      mem_wd = q_cand.box;
      mem_ra = i_ff[IdxW-1:0];
      case (state_ff)
         S_LOAD: mem_we = accept && (cnt_ff < CntW'(MaxBoxes));
         S_GRAB: mem_ra = i_ff[IdxW-1:0] - 1'b1;
         S_CMP: begin
            mem_we = 1'b1;
            mem_wa = j_ff[IdxW-1:0];
            mem_wd = shift_c ? rd_ff : cur_ff;
            mem_ra = j_ff[IdxW-1:0] - IdxW'(2);
         end
         S_TEST: mem_ra = j_ff[IdxW-1:0];
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_wa] <= mem_wd;
      rd_ff <= store_mem[mem_ra];
   end

   // Overlap geometry between ref_ff and cur_ff.
   logic signed [14:0] ax2, bx2, ay2, by2, x1, y1, x2, y2, dx, dy;
   always_comb begin
      ax2 = 15'(ref_ff.x) + 15'($signed({2'b0, ref_ff.w}));
      bx2 = 15'(cur_ff.x) + 15'($signed({2'b0, cur_ff.w}));
      ay2 = 15'(ref_ff.y) + 15'($signed({2'b0, ref_ff.h}));
      by2 = 15'(cur_ff.y) + 15'($signed({2'b0, cur_ff.h}));
      x1 = (ref_ff.x > cur_ff.x) ? 15'(ref_ff.x) : 15'(cur_ff.x);
      y1 = (ref_ff.y > cur_ff.y) ? 15'(ref_ff.y) : 15'(cur_ff.y);
      x2 = (ax2 < bx2) ? ax2 : bx2;
      y2 = (ay2 < by2) ? ay2 : by2;
      dx = x2 - x1;
      dy = y2 - y1;
   end
   logic ovl_c;
   assign ovl_c = (x2 > x1) && (y2 > y1);

   logic [43:0] lhs_c, rhs_c;
   assign lhs_c = {1'b0, inter_ff, 16'd0};
   assign rhs_c = 44'(uni_ff) * 44'(threshold);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         supp_ff <= '0;
         ovalid_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         tph_ff <= PH_READ;
      end else begin
         if (load_out_c) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
         case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (cnt_ff < CntW'(MaxBoxes)) cnt_ff <= cnt_ff + 1'b1;
                  else ovf_ff <= 1'b1;
                  if (q_cand.last) begin
                     i_ff <= CntW'(1);
                     state_ff <= S_PICK;
                  end
               end
            end
            S_PICK: begin
               // Start inserting entry i; its read is issued in this cycle.
               if (i_ff == cnt_ff) begin
                  i_ff <= '0;
                  supp_ff <= '0;
                  pend_v_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_GRAB;
               end
            end
            S_GRAB: begin
               cur_ff <= rd_ff;
               j_ff <= i_ff;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (shift_c) begin
                  j_ff <= j_ff - 1'b1;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_PICK;
               end
            end
            S_SCAN: begin
               // Find next unsuppressed box in ranking.
               if (i_ff == cnt_ff) begin
                  state_ff <= S_WAIT;
               end else if (supp_ff[i_ff[IdxW-1:0]]) begin
                  i_ff <= i_ff + 1'b1;
               end else begin
                  state_ff <= S_REF;
               end
            end
            S_REF: begin
               ref_ff <= rd_ff;
               j_ff <= i_ff + 1'b1;
               tph_ff <= PH_READ;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // Previous pending kept box is known not to be final.
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     obox_ff <= pend_ff;
                     ofin_ff <= 1'b0;
                     oovf_ff <= ovf_ff;
                  end
                  pend_ff <= ref_ff;
                  pend_v_ff <= 1'b1;
                  state_ff <= S_TEST;
               end
            end
            S_TEST: begin
               case (tph_ff)
                  PH_READ: begin
                     if (j_ff == cnt_ff) begin
                        i_ff <= i_ff + 1'b1;
                        state_ff <= S_SCAN;
                     end else if (supp_ff[j_ff[IdxW-1:0]]) begin
                        j_ff <= j_ff + 1'b1;
                     end else begin
                        tph_ff <= PH_GRAB;
                     end
                  end
                  PH_GRAB: begin
                     cur_ff <= rd_ff;
                     tph_ff <= PH_GEOM;
                  end
                  PH_GEOM: begin
                     ov_ff <= ovl_c;
                     dx_ff <= dx[13:0];
                     dy_ff <= dy[13:0];
                     tph_ff <= PH_MUL;
                  end
                  PH_MUL: begin
                     inter_ff <= 27'(dx_ff) * 27'(dy_ff);
                     area_a_ff <= 27'(ref_ff.w) * 27'(ref_ff.h);
                     area_b_ff <= 27'(cur_ff.w) * 27'(cur_ff.h);
                     tph_ff <= PH_UNION;
                  end
                  PH_UNION: begin
                     uni_ff <= {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, inter_ff};
                     tph_ff <= PH_CMP;
                  end
                  default: begin
                     if (ov_ff && lhs_c > rhs_c) supp_ff[j_ff[IdxW-1:0]] <= 1'b1;
                     j_ff <= j_ff + 1'b1;
                     tph_ff <= PH_READ;
                  end
               endcase
            end
            S_WAIT: begin
               if (out_free) begin
                  obox_ff <= pend_ff;
                  ofin_ff <= 1'b1;
                  oovf_ff <= ovf_ff;
                  pend_v_ff <= 1'b0;
                  cnt_ff <= '0;
                  ovf_ff <= 1'b0;
                  supp_ff <= '0;
                  state_ff <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule
`default_nettype wire
